// ----- hw/rtl/tca_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tca_pkg - shared types and constants
// Sizes, register indexes and pair-ordering helpers for the correlator.
// ----------------------------------------------------------------------------
package tca_pkg;

  localparam int LAG_DEPTH   = 16;
  localparam int VALS        = 2;                   // values per time sample
  localparam int NPMAX       = VALS * VALS;
  localparam int SLOT_W      = $clog2(LAG_DEPTH);
  localparam int HELD_W      = $clog2(LAG_DEPTH + 1);
  localparam int VIDX_W      = (VALS > 1) ? $clog2(VALS) : 1;
  localparam int PIDX_W      = (NPMAX > 1) ? $clog2(NPMAX) : 1;
  localparam int NP_W        = $clog2(NPMAX + 1);
  localparam int RING_DEPTH  = LAG_DEPTH * VALS;
  localparam int RING_AW     = $clog2(RING_DEPTH);
  localparam int SUM_DEPTH   = LAG_DEPTH * NPMAX;
  localparam int SUM_AW      = $clog2(SUM_DEPTH);

  localparam int SAMPLE_W    = 16;
  localparam int SUM_W       = 48;
  localparam int CNT_W       = 32;
  localparam int SCALE_W     = 16;
  localparam int LAG_W       = 4;
  localparam int PAIR_W      = 2;
  localparam int MUL_B_W     = 25;
  localparam int MUL_P_W     = SCALE_W + MUL_B_W;
  localparam int HALF_W      = SUM_W / 2;
  localparam int NUM_W       = 64;
  localparam int DVD_W       = 55;                  // (|num| + c*128) >> 8
  localparam int DCNT_W      = $clog2(DVD_W + 1);
  localparam int OUT_TDATA_W = 88;
  localparam int OUT_PAD_W   = OUT_TDATA_W - (LAG_W + PAIR_W + CNT_W + SUM_W);

  localparam int CFG_AW      = 2;
  localparam int CFG_W       = 16;
  localparam logic [CFG_AW-1:0] CFG_PAIR_MODE = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_AVG_MODE  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_SCALE     = 2'd2;

  localparam logic [2:0] PM_AUTO       = 3'd0;
  localparam logic [2:0] PM_UPPER      = 3'd1;
  localparam logic [2:0] PM_LOWER      = 3'd2;
  localparam logic [2:0] PM_AUTO_UPPER = 3'd3;
  localparam logic [2:0] PM_AUTO_LOWER = 3'd4;
  localparam logic [2:0] PM_FULL       = 3'd5;

  localparam logic signed [SCALE_W-1:0] SCALE_RST = 16'sd256;
  localparam logic signed [SUM_W-1:0]   SUM_MAX   = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0]   SUM_MIN   = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [VIDX_W-1:0] i;   // lagged sample value
    logic [VIDX_W-1:0] j;   // newest sample value
  } pair_t;

  function automatic logic pair_used(input logic [2:0] mode, input int i, input int j);
    logic r;
    unique case (mode)
      PM_UPPER:      r = (j > i);
      PM_LOWER:      r = (j < i);
      PM_AUTO_UPPER: r = (j >= i);
      PM_AUTO_LOWER: r = (j <= i);
      PM_FULL:       r = 1'b1;
      default:       r = (j == i);
    endcase
    return r;
  endfunction

  function automatic logic [NP_W-1:0] pair_count(input logic [2:0] mode);
    logic [NP_W-1:0] n;
    n = '0;
    for (int i = 0; i < VALS; i++)
      for (int j = 0; j < VALS; j++)
        if (pair_used(mode, i, j)) n = n + NP_W'(1);
    return n;
  endfunction

  function automatic pair_t pair_at(input logic [2:0] mode, input logic [PIDX_W-1:0] p);
    pair_t r;
    logic [NP_W-1:0] n;
    r = '0;
    n = '0;
    for (int i = 0; i < VALS; i++)
      for (int j = 0; j < VALS; j++)
        if (pair_used(mode, i, j)) begin
          if (n == NP_W'(p)) begin
            r.i = VIDX_W'(i);
            r.j = VIDX_W'(j);
          end
          n = n + NP_W'(1);
        end
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tca_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tca_mul - shared signed multiplier
// 16 x 25 bit signed product with a registered output.
// ----------------------------------------------------------------------------
module tca_mul (
  input  wire                                         clk,
  input  wire logic signed [tca_pkg::SCALE_W-1:0]     a,
  input  wire logic signed [tca_pkg::MUL_B_W-1:0]     b,
  output logic signed [tca_pkg::MUL_P_W-1:0]          prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= tca_pkg::MUL_P_W'(a) * tca_pkg::MUL_P_W'(b);
  end

endmodule
`default_nettype wire

// ----- hw/rtl/tca_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tca_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tca_div (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  input  wire logic [tca_pkg::DVD_W-1:0]        dividend,
  input  wire logic [tca_pkg::CNT_W-1:0]        divisor,
  output logic                                  done_r,
  output logic [tca_pkg::DVD_W-1:0]             quot_r
);

  logic [tca_pkg::CNT_W-1:0]  rem_r;
  logic [tca_pkg::CNT_W-1:0]  dsr_r;
  logic [tca_pkg::DCNT_W-1:0] cnt_r;
  logic [tca_pkg::CNT_W:0]    rem_sh;
  logic                       fits;

  assign rem_sh = {rem_r, quot_r[tca_pkg::DVD_W-1]};
  assign fits   = (rem_sh >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r  <= tca_pkg::DCNT_W'(tca_pkg::DVD_W);
        quot_r <= dividend;
        dsr_r  <= divisor;
        rem_r  <= '0;
      end else if (cnt_r != '0) begin
        rem_r  <= fits ? tca_pkg::CNT_W'(rem_sh - {1'b0, dsr_r})
                       : tca_pkg::CNT_W'(rem_sh);
        quot_r <= {quot_r[tca_pkg::DVD_W-2:0], fits};
        cnt_r  <= cnt_r - tca_pkg::DCNT_W'(1);
        done_r <= (cnt_r == tca_pkg::DCNT_W'(1));
      end
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/time_correlation_accumulator.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// time_correlation_accumulator - lagged product correlator
// Collects time samples into a ring, accumulates per-lag per-pair products
// and reports scaled averages through one shared multiplier and a divider.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                         | tuser       | tlast
//  in_     | in  | sample_value[15:0]            | report_now  | -
//  out_    | out | lag[3:0] pair[5:4] count[37:6]| -           | last_result
//          |     | average[85:38] zero[87:86]    |             |
//  cfg_    | in  | cfg_we / cfg_addr / cfg_wdata, write only
//
//  A value that does not complete a sample is stored in the ring and advances the value position.
//  A completing value runs the read, multiply and add states once per held lag
//  and pair (once per lag when there are no pairs) on the shared multiplier.
//  A report then reads and forms scale*sum for each result, waits on the
//  bit-serial divider (skipped when the count is 0) and loads the output
//  register, then closes in ST_FIN and, in clearing mode, starts a
//  re-accumulation of lag 0. Output stalls hold the sequencer in place.
//  Reset (rst_n low, synchronous) clears control state and valid bits; no
//  clearing pass is needed.
// ----------------------------------------------------------------------------
module time_correlation_accumulator (
  input  wire                                   clk,
  input  wire                                   rst_n,
  // input channel
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire logic [15:0]                      in_tdata,   // sample_value
  input  wire logic                             in_tuser,   // report_now
  // result channel
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [tca_pkg::OUT_TDATA_W-1:0]       out_tdata,  // lag, pair, count, avg
  output logic                                  out_tlast,  // last_result
  // configuration
  input  wire                                   cfg_we,
  input  wire logic [tca_pkg::CFG_AW-1:0]       cfg_addr,
  input  wire logic [tca_pkg::CFG_W-1:0]        cfg_wdata
);

  typedef enum logic [10:0] {
    ST_IDLE = 11'b00000000001,
    ST_ARD  = 11'b00000000010,   // accumulate: issue reads
    ST_AMUL = 11'b00000000100,   // accumulate: multiply
    ST_AADD = 11'b00000001000,   // accumulate: add, saturate, write
    ST_RRD  = 11'b00000010000,   // report: issue reads
    ST_RLO  = 11'b00000100000,   // report: scale * sum low half
    ST_RHI  = 11'b00001000000,   // report: scale * sum high half
    ST_RSUM = 11'b00010000000,   // report: combine, launch divider
    ST_RDIV = 11'b00100000000,   // report: wait for quotient
    ST_ROUT = 11'b01000000000,   // report: hand result to output reg
    ST_FIN  = 11'b10000000000    // report done: clear or return
  } state_t;

  state_t state_r;

  // configuration
  logic [2:0]                          pair_mode_r;
  logic                                avg_mode_r;
  logic signed [tca_pkg::SCALE_W-1:0]  scale_r;

  // sequencing
  logic [tca_pkg::SLOT_W-1:0]  newest_r;
  logic [tca_pkg::HELD_W-1:0]  held_r;
  logic [tca_pkg::VIDX_W-1:0]  vpos_r;
  logic                        rep_r;
  logic [tca_pkg::SLOT_W-1:0]  k_r;
  logic [tca_pkg::PIDX_W-1:0]  p_r;

  // storage
  logic signed [tca_pkg::SAMPLE_W-1:0] ring_mem [tca_pkg::RING_DEPTH];
  logic signed [tca_pkg::SUM_W-1:0]    sum_mem  [tca_pkg::SUM_DEPTH];
  logic [tca_pkg::CNT_W-1:0]           cnt_mem  [tca_pkg::LAG_DEPTH];
  logic [tca_pkg::SUM_DEPTH-1:0]       sum_vld_r;
  logic [tca_pkg::LAG_DEPTH-1:0]       cnt_vld_r;
  logic signed [tca_pkg::SAMPLE_W-1:0] ring_a_r, ring_b_r;
  logic signed [tca_pkg::SUM_W-1:0]    sum_rd_r;
  logic [tca_pkg::CNT_W-1:0]           cnt_rd_r;
  logic                                sum_rv_r, cnt_rv_r;

  // report datapath
  logic signed [tca_pkg::SUM_W-1:0]    sum_q_r;
  logic [tca_pkg::CNT_W-1:0]           cnt_q_r;
  logic signed [tca_pkg::MUL_P_W-1:0]  lo_r;
  logic                                neg_r;
  logic signed [tca_pkg::SUM_W-1:0]    res_r;

  // output register
  logic                                out_valid_r;
  logic [tca_pkg::LAG_W-1:0]           out_lag_r;
  logic [tca_pkg::PAIR_W-1:0]          out_pair_r;
  logic [tca_pkg::CNT_W-1:0]           out_cnt_r;
  logic signed [tca_pkg::SUM_W-1:0]    out_avg_r;
  logic                                out_last_r;

  // ---------------------------------------------------------------- decode
  logic                                in_acc;
  logic [tca_pkg::SLOT_W-1:0]          slot_next;
  logic [tca_pkg::NP_W-1:0]            np;
  tca_pkg::pair_t                      pr;
  logic [tca_pkg::SLOT_W-1:0]          lag_slot;
  logic [tca_pkg::RING_AW-1:0]         ring_wa, ring_ra_a, ring_ra_b;
  logic [tca_pkg::SUM_AW-1:0]          sum_a;
  logic                                p_last, k_last_acc, k_last_rep;
  logic signed [tca_pkg::SUM_W-1:0]    sum_val;
  logic [tca_pkg::CNT_W-1:0]           cnt_val;
  logic signed [tca_pkg::SUM_W:0]      acc_sum;
  logic signed [tca_pkg::SUM_W-1:0]    acc_sat;
  logic [tca_pkg::CNT_W-1:0]           cnt_inc;
  logic                                sum_we, cnt_we;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign slot_next = (newest_r == tca_pkg::SLOT_W'(tca_pkg::LAG_DEPTH - 1))
                   ? '0 : newest_r + tca_pkg::SLOT_W'(1);
  assign np        = tca_pkg::pair_count(pair_mode_r);
  assign pr        = tca_pkg::pair_at(pair_mode_r, p_r);
  assign lag_slot  = (newest_r >= k_r) ? newest_r - k_r
                   : tca_pkg::SLOT_W'(newest_r + tca_pkg::SLOT_W'(tca_pkg::LAG_DEPTH) - k_r);

  assign ring_wa   = tca_pkg::RING_AW'(slot_next) * tca_pkg::RING_AW'(tca_pkg::VALS)
                   + tca_pkg::RING_AW'(vpos_r);
  assign ring_ra_a = tca_pkg::RING_AW'(lag_slot) * tca_pkg::RING_AW'(tca_pkg::VALS)
                   + tca_pkg::RING_AW'(pr.i);
  assign ring_ra_b = tca_pkg::RING_AW'(newest_r) * tca_pkg::RING_AW'(tca_pkg::VALS)
                   + tca_pkg::RING_AW'(pr.j);
  assign sum_a     = tca_pkg::SUM_AW'(k_r) * tca_pkg::SUM_AW'(tca_pkg::NPMAX)
                   + tca_pkg::SUM_AW'(p_r);

  // modes without pairs still walk one step per lag to bump the counts
  assign p_last     = (np == '0) || (tca_pkg::NP_W'(p_r) == np - tca_pkg::NP_W'(1));
  assign k_last_acc = (tca_pkg::HELD_W'(k_r) + tca_pkg::HELD_W'(1)) >= held_r;
  assign k_last_rep = (k_r == tca_pkg::SLOT_W'(tca_pkg::LAG_DEPTH - 1));

  // entries without a valid bit read as zero
  assign sum_val = sum_rv_r ? sum_rd_r : '0;
  assign cnt_val = cnt_rv_r ? cnt_rd_r : '0;

  // ---------------------------------------------------------- multiplier
  logic signed [tca_pkg::SCALE_W-1:0]  mul_a;
  logic signed [tca_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [tca_pkg::MUL_P_W-1:0]  mul_p;

  always_comb begin
    mul_a = scale_r;
    mul_b = '0;
    priority case (1'b1)
      state_r[$clog2(ST_AMUL)]: begin
        mul_a = ring_a_r;
        mul_b = tca_pkg::MUL_B_W'(ring_b_r);
      end
      state_r[$clog2(ST_RLO)]: begin
        mul_b = {1'b0, sum_val[tca_pkg::HALF_W-1:0]};
      end
      state_r[$clog2(ST_RHI)]: begin
        mul_b = tca_pkg::MUL_B_W'($signed(sum_q_r[tca_pkg::SUM_W-1:tca_pkg::HALF_W]));
      end
      default: begin
        mul_b = '0;
      end
    endcase
  end

  tca_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (mul_p)
  );

  // accumulate add with saturation; product of two Q8.8 fits in 32 bits
  assign acc_sum = {sum_val[tca_pkg::SUM_W-1], sum_val}
                 + {{(tca_pkg::SUM_W-31){mul_p[31]}}, mul_p[31:0]};
  assign acc_sat = (acc_sum[tca_pkg::SUM_W] != acc_sum[tca_pkg::SUM_W-1])
                 ? (acc_sum[tca_pkg::SUM_W] ? tca_pkg::SUM_MIN : tca_pkg::SUM_MAX)
                 : acc_sum[tca_pkg::SUM_W-1:0];
  assign cnt_inc = (cnt_val == '1) ? cnt_val : cnt_val + tca_pkg::CNT_W'(1);

  assign sum_we = (state_r == ST_AADD) && (np != '0);
  assign cnt_we = (state_r == ST_AADD) && p_last;

  // -------------------------------------------------------------- divider
  logic signed [tca_pkg::NUM_W-1:0]    num;
  logic [tca_pkg::NUM_W-1:0]           mag;
  logic [tca_pkg::NUM_W-1:0]           rnd;
  logic                                div_start, div_done;
  logic [tca_pkg::DVD_W-1:0]           quot;
  logic signed [tca_pkg::SUM_W-1:0]    q_sat;

  assign num = (tca_pkg::NUM_W'(mul_p) <<< tca_pkg::HALF_W) + tca_pkg::NUM_W'(lo_r);
  assign mag = num[tca_pkg::NUM_W-1] ? tca_pkg::NUM_W'(-num) : tca_pkg::NUM_W'(num);
  // round half away: floor((|n| + c*128) / (c*256)) = floor(((|n| + c*128) >> 8) / c)
  assign rnd = mag + (tca_pkg::NUM_W'(cnt_q_r) << 7);
  assign div_start = (state_r == ST_RSUM) && (cnt_q_r != '0);

  tca_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rnd[tca_pkg::DVD_W+7:8]),
    .divisor  (cnt_q_r),
    .done_r   (div_done),
    .quot_r   (quot)
  );

  always_comb begin
    if (neg_r) begin
      q_sat = (quot >= tca_pkg::DVD_W'(tca_pkg::SUM_MAX) + tca_pkg::DVD_W'(1))
            ? tca_pkg::SUM_MIN : tca_pkg::SUM_W'(-quot[tca_pkg::SUM_W-1:0]);
    end else begin
      q_sat = (quot > tca_pkg::DVD_W'(tca_pkg::SUM_MAX))
            ? tca_pkg::SUM_MAX : quot[tca_pkg::SUM_W-1:0];
    end
  end

  // ------------------------------------------------------------- memories
  always_ff @(posedge clk) begin
    if (in_acc) ring_mem[ring_wa] <= in_tdata;
    ring_a_r <= ring_mem[ring_ra_a];
    ring_b_r <= ring_mem[ring_ra_b];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[sum_a] <= acc_sat;
    sum_rd_r <= sum_mem[sum_a];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[k_r] <= cnt_inc;
    cnt_rd_r <= cnt_mem[k_r];
  end

  always_ff @(posedge clk) begin
    sum_rv_r <= sum_vld_r[sum_a];
    cnt_rv_r <= cnt_vld_r[k_r];
  end

  // ------------------------------------------------------------ sequencer
  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pair_mode_r <= tca_pkg::PM_AUTO;
      avg_mode_r  <= 1'b0;
      scale_r     <= tca_pkg::SCALE_RST;
      newest_r    <= tca_pkg::SLOT_W'(tca_pkg::LAG_DEPTH - 1);
      held_r      <= '0;
      vpos_r      <= '0;
      rep_r       <= 1'b0;
      k_r         <= '0;
      p_r         <= '0;
      sum_vld_r   <= '0;
      cnt_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          tca_pkg::CFG_PAIR_MODE: pair_mode_r <= cfg_wdata[2:0];
          tca_pkg::CFG_AVG_MODE:  avg_mode_r  <= cfg_wdata[0];
          tca_pkg::CFG_SCALE:     scale_r     <= cfg_wdata;
          default: ;
        endcase
      end

      // ST_ROUT reloads the output register itself
      if (out_valid_r && out_tready && (state_r != ST_ROUT)) out_valid_r <= 1'b0;
      if (sum_we) sum_vld_r[sum_a] <= 1'b1;
      if (cnt_we) cnt_vld_r[k_r]   <= 1'b1;

      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (tca_pkg::VIDX_W'(vpos_r) == tca_pkg::VIDX_W'(tca_pkg::VALS - 1)) begin
              vpos_r   <= '0;
              newest_r <= slot_next;
              if (held_r < tca_pkg::HELD_W'(tca_pkg::LAG_DEPTH))
                held_r <= held_r + tca_pkg::HELD_W'(1);
              rep_r    <= in_tuser;
              k_r      <= '0;
              p_r      <= '0;
              state_r  <= ST_ARD;
            end else begin
              vpos_r <= vpos_r + tca_pkg::VIDX_W'(1);
            end
          end
        end
        ST_ARD:  state_r <= ST_AMUL;
        ST_AMUL: state_r <= ST_AADD;
        ST_AADD: begin
          if (!p_last) begin
            p_r     <= p_r + tca_pkg::PIDX_W'(1);
            state_r <= ST_ARD;
          end else if (!k_last_acc) begin
            k_r     <= k_r + tca_pkg::SLOT_W'(1);
            p_r     <= '0;
            state_r <= ST_ARD;
          end else begin
            k_r     <= '0;
            p_r     <= '0;
            if (!rep_r)          state_r <= ST_IDLE;
            else if (np == '0)   state_r <= ST_FIN;
            else                 state_r <= ST_RRD;
          end
        end
        ST_RRD:  state_r <= ST_RLO;
        ST_RLO: begin
          sum_q_r <= sum_val;
          cnt_q_r <= cnt_val;
          state_r <= ST_RHI;
        end
        ST_RHI: begin
          lo_r    <= mul_p;
          state_r <= ST_RSUM;
        end
        ST_RSUM: begin
          neg_r <= num[tca_pkg::NUM_W-1];
          if (cnt_q_r == '0) begin
            res_r   <= '0;
            state_r <= ST_ROUT;
          end else begin
            state_r <= ST_RDIV;
          end
        end
        ST_RDIV: begin
          if (div_done) begin
            res_r   <= q_sat;
            state_r <= ST_ROUT;
          end
        end
        ST_ROUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_lag_r   <= tca_pkg::LAG_W'(k_r);
            out_pair_r  <= tca_pkg::PAIR_W'(p_r);
            out_cnt_r   <= cnt_q_r;
            out_avg_r   <= res_r;
            out_last_r  <= k_last_rep && p_last;
            if (!p_last) begin
              p_r     <= p_r + tca_pkg::PIDX_W'(1);
              state_r <= ST_RRD;
            end else if (!k_last_rep) begin
              k_r     <= k_r + tca_pkg::SLOT_W'(1);
              p_r     <= '0;
              state_r <= ST_RRD;
            end else begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          k_r   <= '0;
          p_r   <= '0;
          rep_r <= 1'b0;
          if (!avg_mode_r) begin
            // clearing mode: drop all sums, then re-accumulate lag 0
            sum_vld_r <= '0;
            cnt_vld_r <= '0;
            held_r    <= tca_pkg::HELD_W'(1);
            state_r   <= ST_ARD;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {{tca_pkg::OUT_PAD_W{1'b0}}, out_avg_r, out_cnt_r, out_pair_r, out_lag_r};

endmodule
`default_nettype wire

// ----- hw/rtl/tca_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tca_checker - port-level checks
// Output channel behavior of the correlator as seen on its ports.
// ----------------------------------------------------------------------------
module tca_checker (
  input wire                                 clk,
  input wire                                 rst_n,
  input wire                                 out_tvalid,
  input wire                                 out_tready,
  input wire [tca_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input wire                                 out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[tca_pkg::OUT_TDATA_W-1 -: tca_pkg::OUT_PAD_W] == '0)
    else $error("tdata padding not zero");

  a_last_lag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |->
      out_tdata[tca_pkg::LAG_W-1:0] == tca_pkg::LAG_W'(tca_pkg::LAG_DEPTH - 1))
    else $error("last result not at the deepest lag");

endmodule

bind time_correlation_accumulator tca_checker u_tca_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
`default_nettype wire
